// ===== rtl/whc_pkg.sv =====
package whc_pkg;

  localparam int unsigned ADDR_BITS  = 8;
  localparam int unsigned FIFO_DEPTH = 3;

  typedef enum logic [2:0] {
    CMD_BYTE   = 3'd0,
    CMD_END    = 3'd1,
    CMD_RD_LEN = 3'd2,
    CMD_RD_CHR = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic {
    REQ_READ = 1'b0,
    REQ_INC  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                 valid;
    req_kind_t            kind;
    logic [ADDR_BITS-1:0] addr;
  } bank_req_t;

  typedef struct packed {
    bank_req_t len_req;
    bank_req_t chr_req;
    logic      clr;
    logic      inv_rd;
    logic      rd;
  } trk_ctl_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        index_invalid;
  } res_t;

  function automatic logic is_separator(input logic [7:0] b);
    logic sep;
    case (b)
      8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h3B,
      8'h22, 8'h20, 8'h0A, 8'h09, 8'h5E, 8'h00: sep = 1'b1;
      default:                                  sep = 1'b0;
    endcase
    return sep;
  endfunction

endpackage

// ===== rtl/whc_in_if.sv =====
interface whc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic [6:0] bin_index;

  modport source (output valid, command, data_byte, bin_index, input ready);
  modport sink   (input valid, command, data_byte, bin_index, output ready);
endinterface

// ===== rtl/whc_out_if.sv =====
interface whc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_count;
  logic        index_invalid;

  modport source (output valid, bin_count, index_invalid, input ready);
  modport sink   (input valid, bin_count, index_invalid, output ready);
endinterface

// ===== rtl/whc_word_tracker.sv =====
module whc_word_tracker #(
  parameter int unsigned MAX_WORD_LEN = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [2:0]         command,
  input  logic [7:0]         data_byte,
  input  logic [6:0]         bin_index,
  output whc_pkg::trk_ctl_t  ctl
);

  localparam int unsigned LENW = $clog2(MAX_WORD_LEN + 1);

  logic [LENW-1:0] cur_len_r;
  logic [LENW-1:0] cur_len_nxt;
  logic            sep;
  logic            chr_ok;
  logic            idx_ok;

  assign sep    = whc_pkg::is_separator(data_byte);
  assign chr_ok = !data_byte[7] && (data_byte[6:1] != 6'd0);
  assign idx_ok = {1'b0, bin_index} < 8'(MAX_WORD_LEN);

  always_comb begin
    ctl         = '0;
    cur_len_nxt = cur_len_r;
    if (acc) begin
      unique case (command)
        whc_pkg::CMD_BYTE: begin
          if (sep) begin
            if (cur_len_r != '0) begin
              ctl.len_req.valid = 1'b1;
              ctl.len_req.kind  = whc_pkg::REQ_INC;
              ctl.len_req.addr  = whc_pkg::ADDR_BITS'(cur_len_r - LENW'(1));
            end
            cur_len_nxt = '0;
          end else if (cur_len_r < LENW'(MAX_WORD_LEN)) begin
            if (chr_ok) begin
              ctl.chr_req.valid = 1'b1;
              ctl.chr_req.kind  = whc_pkg::REQ_INC;
              ctl.chr_req.addr  = {1'b0, data_byte[6:0]};
            end
            cur_len_nxt = cur_len_r + LENW'(1);
          end
        end
        whc_pkg::CMD_END: begin
          if (cur_len_r != '0) begin
            ctl.len_req.valid = 1'b1;
            ctl.len_req.kind  = whc_pkg::REQ_INC;
            ctl.len_req.addr  = whc_pkg::ADDR_BITS'(cur_len_r - LENW'(1));
          end
          cur_len_nxt = '0;
        end
        whc_pkg::CMD_RD_LEN: begin
          ctl.rd = 1'b1;
          if (idx_ok) begin
            ctl.len_req.valid = 1'b1;
            ctl.len_req.kind  = whc_pkg::REQ_READ;
            ctl.len_req.addr  = {1'b0, bin_index};
          end else begin
            ctl.inv_rd = 1'b1;
          end
        end
        whc_pkg::CMD_RD_CHR: begin
          ctl.rd            = 1'b1;
          ctl.chr_req.valid = 1'b1;
          ctl.chr_req.kind  = whc_pkg::REQ_READ;
          ctl.chr_req.addr  = {1'b0, bin_index};
        end
        whc_pkg::CMD_CLEAR: begin
          ctl.clr     = 1'b1;
          cur_len_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r <= '0;
    end else begin
      cur_len_r <= cur_len_nxt;
    end
  end

endmodule

// ===== rtl/whc_hist_bank.sv =====
module whc_hist_bank #(
  parameter int unsigned DEPTH    = 30,
  parameter int unsigned CNT_W    = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  whc_pkg::bank_req_t req,
  input  logic               clr,
  output logic               rd_valid,
  output logic [CNT_W-1:0]   rd_count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;

  logic [CNT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic             s1_valid_r;
  logic             s1_inc_r;
  logic [AW-1:0]    s1_addr_r;

  logic             wb_v_r;
  logic [AW-1:0]    wb_addr_r;
  logic [CNT_W-1:0] wb_data_r;

  logic [AW-1:0]    req_idx;
  logic             fwd_hit;
  logic             wr_en;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] sum;

  assign req_idx = req.addr[AW-1:0];
  assign fwd_hit = wb_v_r && (wb_addr_r == s1_addr_r);
  assign cur     = fwd_hit ? wb_data_r : (rd_vld_r ? rd_data_r : '0);
  assign sum     = cur + CNT_W'(1);
  assign wr_en   = s1_valid_r && s1_inc_r;

  assign rd_valid = s1_valid_r && !s1_inc_r;
  assign rd_count = cur;

  // read stage and write-back into the same array
  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd_data_r <= mem_r[req_idx];
      rd_vld_r  <= vld_r[req_idx];
    end
    if (wr_en) begin
      mem_r[s1_addr_r] <= sum;
    end
    s1_inc_r  <= (req.kind == whc_pkg::REQ_INC);
    s1_addr_r <= req_idx;
    wb_addr_r <= s1_addr_r;
    wb_data_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
      wb_v_r     <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
      wb_v_r     <= wr_en;
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/whc_result_fifo.sv =====
module whc_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  whc_pkg::res_t       push_data,
  output logic [1:0]          count,
  whc_out_if.source           out_chan
);

  whc_pkg::res_t ent_r [whc_pkg::FIFO_DEPTH];
  logic [1:0]    wr_ptr_r;
  logic [1:0]    rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(whc_pkg::FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign pop                    = out_chan.valid && out_chan.ready;
  assign count                  = cnt_r;
  assign out_chan.valid         = (cnt_r != 2'd0);
  assign out_chan.bin_count     = ent_r[rd_ptr_r].bin_count;
  assign out_chan.index_invalid = ent_r[rd_ptr_r].index_invalid;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/word_and_char_histogram.sv =====
// Word-length and character histogram over a byte stream.
//
// in_chan carries one command per transfer: a text byte, end of text, a
// length-bin read, a char-bin read or a clear. out_chan carries one result
// (bin_count, index_invalid) per read command, in command order.
//
// A new command can be taken on every clock, so the sustained rate is one
// command per clock while in_chan.ready is high. A read result passes
// through the bank's read stage (or the invalid-index register) and the
// result queue before it is visible on out_chan. Counting is a read-modify-write
// on a synchronous-read memory per histogram; back-to-back hits on the same
// bin are forwarded from the write-back.
// Reset and the clear command empty both histograms at once through per-bin
// valid bits, with no sweep: the next command may follow immediately.
// Results wait in a three-entry queue; while out_chan is stalled, input keeps
// flowing until that queue and the read in flight would fill it, then
// in_chan.ready drops. Non-read commands are also held back at that point.
module word_and_char_histogram #(
  parameter int unsigned MAX_WORD_LEN = 30,
  parameter int unsigned COUNT_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  whc_in_if.sink     in_chan,
  whc_out_if.source  out_chan
);

  localparam int unsigned CHAR_BINS = 128;

  whc_pkg::trk_ctl_t    ctl;
  logic                 in_acc;
  logic                 inv_r;
  logic                 rd_pend_r;
  logic [1:0]           fifo_cnt;
  logic                 len_rd_v;
  logic                 chr_rd_v;
  logic [COUNT_BITS-1:0] len_cnt;
  logic [COUNT_BITS-1:0] chr_cnt;
  logic                 push;
  whc_pkg::res_t        push_data;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (3'(fifo_cnt) + 3'(rd_pend_r)) < 3'(whc_pkg::FIFO_DEPTH);

  whc_word_tracker #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .command   (in_chan.command),
    .data_byte (in_chan.data_byte),
    .bin_index (in_chan.bin_index),
    .ctl       (ctl)
  );

  whc_hist_bank #(
    .DEPTH (MAX_WORD_LEN),
    .CNT_W (COUNT_BITS)
  ) u_len_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ctl.len_req),
    .clr      (ctl.clr),
    .rd_valid (len_rd_v),
    .rd_count (len_cnt)
  );

  whc_hist_bank #(
    .DEPTH (CHAR_BINS),
    .CNT_W (COUNT_BITS)
  ) u_chr_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (ctl.chr_req),
    .clr      (ctl.clr),
    .rd_valid (chr_rd_v),
    .rd_count (chr_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      inv_r     <= ctl.inv_rd;
      rd_pend_r <= ctl.rd;
    end
  end

  assign push = len_rd_v || chr_rd_v || inv_r;

  always_comb begin
    push_data.index_invalid = inv_r;
    if (inv_r) begin
      push_data.bin_count = 32'd0;
    end else if (len_rd_v) begin
      push_data.bin_count = 32'(len_cnt);
    end else begin
      push_data.bin_count = 32'(chr_cnt);
    end
  end

  whc_result_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_cnt),
    .out_chan  (out_chan)
  );

endmodule

// ===== rtl/whc_checker.sv =====
module whc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bin_count,
  input logic        out_index_invalid
);

  logic [2:0] pend_r;
  logic       rd_acc;
  logic       out_acc;

  assign rd_acc  = in_valid && in_ready &&
                   ((in_command == whc_pkg::CMD_RD_LEN) ||
                    (in_command == whc_pkg::CMD_RD_CHR));
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + 3'(rd_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bin_count) && $stable(out_index_invalid))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a pending read");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_invalid |-> out_bin_count == 32'd0)
    else $error("invalid index with nonzero count");

endmodule

bind word_and_char_histogram whc_checker u_whc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_command        (in_chan.command),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_bin_count     (out_chan.bin_count),
  .out_index_invalid (out_chan.index_invalid)
);
